>>> design/hdce_pkg.sv
`timescale 1ns / 1ps

package hdce_pkg;

  localparam int BUCKET_COUNT = 4093;
  localparam int BUCKET_W = $clog2(BUCKET_COUNT);
  localparam int ROW_BITS = 32;
  localparam int BIT_IDX_W = $clog2(ROW_BITS);
  localparam int ROW_COUNT = (BUCKET_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_IDX_W = $clog2(ROW_COUNT);

  localparam int COORD_W = 32;
  localparam int EST_W = 12;
  localparam int COUNT_MAX = (1 << EST_W) - 1;

  // Folding constants: 2^12 is congruent to FOLD_K modulo the bucket count.
  localparam int FOLD_K = (1 << BUCKET_W) - BUCKET_COUNT;
  localparam int FOLD_K2 = FOLD_K * FOLD_K;
  localparam int WRAP_REM = (FOLD_K2 * (1 << (COORD_W - 2 * BUCKET_W))) % BUCKET_COUNT;
  localparam int NEG_ADJ = BUCKET_COUNT - WRAP_REM;
  localparam int FOLD_W = 15;
  localparam int RED_W = 13;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic fold;
    logic reduce;
    logic read;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last_item;
  } status_t;

endpackage

>>> design/hashed_distinct_count_estimator_top.sv
`timescale 1ns / 1ps

// Distinct-value estimator for a stream of 2D points using a hashed occupancy bitmap.
// Points arrive as command beats: a beat is taken at a clock edge where start is high
// and busy is low. The coordinate selected by the use_y_coordinate register (APB
// address 0, bit 0) is reduced modulo 4093 and marks one bucket of the bitmap.
// Each point passes through the accepting cycle, the fold and reduce folding states,
// a bitmap read and a read-modify-write. busy is low again in the cycle after the
// read-modify-write unless last_point was set, so the block never holds two points.
// A point flagged with last_point produces one result: done is high for exactly one
// cycle, registered from the read-modify-write, with distinct_estimate holding
// the count of buckets first occupied during the run. The receiver cannot stall and
// must take the beat in that cycle. After the result the bitmap is cleared one
// 32-bit row per cycle, all 128 rows, with busy held high. The same clearing pass runs
// after reset, so busy stays high once rst falls until that pass ends. Reset also
// returns use_y_coordinate to zero. Register writes are taken at any time.

module hashed_distinct_count_estimator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hdce_pkg::COORD_W-1:0] x_value,
  input  logic signed [hdce_pkg::COORD_W-1:0] y_value,
  input  logic                                last_point,
  output logic                                done,
  output logic [hdce_pkg::EST_W-1:0]          distinct_estimate,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hdce_pkg::ADDR_W-1:0]         paddr,
  input  logic [hdce_pkg::DATA_W-1:0]         pwdata,
  output logic [hdce_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import hdce_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    use_y_coordinate;
  logic    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      use_y_coordinate <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      use_y_coordinate <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {{(DATA_W-1){1'b0}}, use_y_coordinate} : '0;

  hdce_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  hdce_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .use_y_coordinate  (use_y_coordinate),
    .x_value           (x_value),
    .y_value           (y_value),
    .last_point        (last_point),
    .status            (status),
    .done              (done),
    .distinct_estimate (distinct_estimate)
  );

endmodule

>>> design/hdce_ctrl.sv
`timescale 1ns / 1ps

module hdce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  hdce_pkg::status_t status,
  output hdce_pkg::cmd_t    cmd,
  output logic             busy
);
  import hdce_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FOLD,
    ST_REDUCE,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD:   state <= ST_REDUCE;
        ST_REDUCE: state <= ST_READ;
        ST_READ:   state <= ST_UPDATE;
        ST_UPDATE: begin
          state <= status.last_item ? ST_CLEAR : ST_IDLE;
        end
        default:   state <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:  cmd.clear_step = 1'b1;
      ST_IDLE:   cmd.load = start;
      ST_FOLD:   cmd.fold = 1'b1;
      ST_REDUCE: cmd.reduce = 1'b1;
      ST_READ:   cmd.read = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      default:   cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> design/hdce_datapath.sv
`timescale 1ns / 1ps

module hdce_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hdce_pkg::cmd_t                        cmd,
  input  logic                                  use_y_coordinate,
  input  logic signed [hdce_pkg::COORD_W-1:0]   x_value,
  input  logic signed [hdce_pkg::COORD_W-1:0]   y_value,
  input  logic                                  last_point,
  output hdce_pkg::status_t                     status,
  output logic                                  done,
  output logic [hdce_pkg::EST_W-1:0]            distinct_estimate
);
  import hdce_pkg::*;

  logic [COORD_W-1:0]   coord;
  logic                 last_q;
  logic [FOLD_W-1:0]    fold_sum;
  logic [FOLD_W-1:0]    fold_next;
  logic [RED_W-1:0]     red_sum;
  logic [BUCKET_W-1:0]  bucket;
  logic [BUCKET_W-1:0]  bucket_next;
  logic [ROW_BITS-1:0]  rd_row;
  logic [ROW_BITS-1:0]  bit_mask;
  logic [ROW_IDX_W-1:0] clr_row;
  logic [EST_W-1:0]     count;
  logic [EST_W-1:0]     count_next;
  logic                 was_empty;

  logic [ROW_BITS-1:0]  mem [ROW_COUNT];
  logic                 mem_we;
  logic [ROW_IDX_W-1:0] mem_waddr;
  logic [ROW_BITS-1:0]  mem_wdata;
  logic [ROW_IDX_W-1:0] bucket_row;

  // A negative coordinate is its unsigned pattern minus 2^32; NEG_ADJ folds that term in.
  assign fold_next = FOLD_W'(coord[31:24]) * FOLD_W'(FOLD_K2)
                   + FOLD_W'(coord[23:12]) * FOLD_W'(FOLD_K)
                   + FOLD_W'(coord[11:0])
                   + (coord[31] ? FOLD_W'(NEG_ADJ) : FOLD_W'(0));

  assign red_sum = RED_W'(fold_sum[FOLD_W-1:BUCKET_W]) * RED_W'(FOLD_K)
                 + RED_W'(fold_sum[BUCKET_W-1:0]);

  assign bucket_next = (red_sum >= RED_W'(BUCKET_COUNT))
                     ? BUCKET_W'(red_sum - RED_W'(BUCKET_COUNT))
                     : BUCKET_W'(red_sum);

  assign bucket_row = bucket[BUCKET_W-1:BIT_IDX_W];
  assign bit_mask   = ROW_BITS'(1) << bucket[BIT_IDX_W-1:0];
  assign was_empty  = ~|(rd_row & bit_mask);
  assign count_next = (was_empty && (count != EST_W'(COUNT_MAX))) ? count + EST_W'(1) : count;

  assign mem_we    = cmd.clear_step | cmd.update;
  assign mem_waddr = cmd.clear_step ? clr_row : bucket_row;
  assign mem_wdata = cmd.clear_step ? '0 : (rd_row | bit_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_row <= mem[bucket_row];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coord  <= use_y_coordinate ? y_value : x_value;
      last_q <= last_point;
    end
    if (cmd.fold) begin
      fold_sum <= fold_next;
    end
    if (cmd.reduce) begin
      bucket <= bucket_next;
    end
    if (cmd.update && last_q) begin
      distinct_estimate <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.update & last_q;
      if (cmd.clear_step) begin
        clr_row <= clr_row + ROW_IDX_W'(1);
        count   <= '0;
      end
      if (cmd.update) begin
        count <= count_next;
      end
    end
  end

  assign status.clear_last = (clr_row == ROW_IDX_W'(ROW_COUNT - 1));
  assign status.last_item  = last_q;

endmodule

>>> design/hdce_checker.sv
`timescale 1ns / 1ps

module hdce_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [hdce_pkg::EST_W-1:0] distinct_estimate
);
  import hdce_pkg::*;

  // The result beat lands while the following clearing pass holds busy high.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_est_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (distinct_estimate <= EST_W'(BUCKET_COUNT)))
    else $error("estimate above bucket count");

  a_reset_clear: assert property (@(posedge clk) disable iff (rst) $fell(rst) |-> busy)
    else $error("block idle right after reset");

endmodule

bind hashed_distinct_count_estimator_top hdce_checker u_hdce_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .done              (done),
  .distinct_estimate (distinct_estimate)
);
